### src/assert_macros.svh
// Assertion helpers shared by the RTL files. Both sample on the rising
// clock edge and stay quiet while reset is applied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

### src/mbrs_pkg.sv
`default_nettype none

package mbrs_pkg;

  localparam int unsigned HEAP_WORDS   = 65536;
  localparam int unsigned BITMAP_WORDS = (HEAP_WORDS + 63) / 64;
  localparam int unsigned WIDX_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BIT_W   = 6;
  localparam int unsigned BMW_W   = 64;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [ADDR_W-1:0] HEAP_START_RESET = 32'd0;
  localparam logic [ADDR_W-1:0] HEAP_END_RESET   = 32'd65536;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [0:0] {
    OP_MARK  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_HEAP_START = 1'b0,
    CFG_HEAP_END   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_MARK,
    CMD_REJECT,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_TEST,
    ST_FILL,
    ST_LAST
  } back_state_e;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    cmd_e              kind;
    logic              err;
    logic [WIDX_W-1:0] first_w;
    logic [WIDX_W-1:0] last_w;
    logic [BIT_W-1:0]  first_b;
    logic [BIT_W-1:0]  last_b;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  // Bits lo..hi inclusive set, lo <= hi.
  function automatic logic [BMW_W-1:0] range_mask(input logic [BIT_W-1:0] lo,
                                                  input logic [BIT_W-1:0] hi);
    return ({BMW_W{1'b1}} << lo) & ({BMW_W{1'b1}} >> (6'd63 - hi));
  endfunction

endpackage

`default_nettype wire

### src/mbrs_front.sv
`default_nettype none

module mbrs_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [mbrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  wire logic                                s_axis_tuser_i,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [mbrs_pkg::ADDR_W-1:0]         cfg_wdata_i,
  input  wire logic                                init_busy_i,
  input  wire logic                                q_ready_i,
  output logic                                     q_push_o,
  output mbrs_pkg::cmd_t                           q_cmd_o
);

  logic [mbrs_pkg::ADDR_W-1:0] heap_start_q;
  logic [mbrs_pkg::ADDR_W-1:0] heap_end_q;

  logic [mbrs_pkg::ADDR_W-1:0] in_addr;
  logic [mbrs_pkg::SIZE_W-1:0] in_size;
  logic                        in_fire;

  logic                        st_valid_q;
  mbrs_pkg::op_e               st_op_q;
  logic                        st_skip_q;
  logic                        st_past_q;
  logic [mbrs_pkg::ADDR_W-1:0] st_idx_q;
  logic [mbrs_pkg::SIZE_W-1:0] st_size_q;

  logic                        skip_d;
  logic                        past_d;
  logic [mbrs_pkg::ADDR_W-1:0] idx_d;

  logic [mbrs_pkg::ADDR_W:0]   last_idx;
  logic                        cap_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= mbrs_pkg::HEAP_START_RESET;
      heap_end_q   <= mbrs_pkg::HEAP_END_RESET;
    end else if (cfg_we_i) begin
      unique case (mbrs_pkg::cfg_reg_e'(cfg_idx_i))
        mbrs_pkg::CFG_HEAP_START: heap_start_q <= cfg_wdata_i;
        mbrs_pkg::CFG_HEAP_END:   heap_end_q   <= cfg_wdata_i;
      endcase
    end
  end

  assign in_addr = s_axis_tdata_i[mbrs_pkg::ADDR_W-1:0];
  assign in_size = s_axis_tdata_i[mbrs_pkg::ADDR_W +: mbrs_pkg::SIZE_W];

  assign q_push_o        = st_valid_q && q_ready_i;
  assign s_axis_tready_o = !init_busy_i && (!st_valid_q || q_ready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // First classification step: heap bounds and the end of the range.
  always_comb begin
    skip_d = (in_addr < heap_start_q) || (in_addr > heap_end_q) ||
             (in_size == '0);
    past_d = ({1'b0, in_addr} + {16'd0, in_size}) > {1'b0, heap_end_q};
    idx_d  = in_addr - heap_start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_fire) begin
      st_valid_q <= 1'b1;
    end else if (q_push_o) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      st_op_q   <= mbrs_pkg::op_e'(s_axis_tuser_i);
      st_skip_q <= skip_d;
      st_past_q <= past_d;
      st_idx_q  <= idx_d;
      st_size_q <= in_size;
    end
  end

  // Second step: bitmap capacity and the word and bit of each range end.
  // The size is known to be nonzero wherever the last index is used.
  assign last_idx = {1'b0, st_idx_q} + {16'd0, st_size_q} - 33'd1;
  assign cap_err  = last_idx >= 33'(mbrs_pkg::HEAP_WORDS);

  always_comb begin
    q_cmd_o.kind    = mbrs_pkg::CMD_MARK;
    q_cmd_o.err     = 1'b0;
    q_cmd_o.first_w = st_idx_q[mbrs_pkg::BIT_W +: mbrs_pkg::WIDX_W];
    q_cmd_o.last_w  = last_idx[mbrs_pkg::BIT_W +: mbrs_pkg::WIDX_W];
    q_cmd_o.first_b = st_idx_q[mbrs_pkg::BIT_W-1:0];
    q_cmd_o.last_b  = last_idx[mbrs_pkg::BIT_W-1:0];
    q_cmd_o.size    = st_size_q;
    priority if (st_op_q == mbrs_pkg::OP_CLEAR) begin
      q_cmd_o.kind = mbrs_pkg::CMD_CLEAR;
    end else if (st_skip_q) begin
      q_cmd_o.kind = mbrs_pkg::CMD_REJECT;
    end else if (st_past_q || cap_err) begin
      q_cmd_o.kind = mbrs_pkg::CMD_REJECT;
      q_cmd_o.err  = 1'b1;
    end else begin
      q_cmd_o.kind = mbrs_pkg::CMD_MARK;
    end
  end

endmodule

`default_nettype wire

### src/mbrs_queue.sv
`default_nettype none

`include "assert_macros.svh"

module mbrs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mbrs_pkg::cmd_t cmd_i,
  output logic                ready_o,
  output logic                valid_o,
  output mbrs_pkg::cmd_t      cmd_o,
  input  wire logic           pop_i
);

  mbrs_pkg::cmd_t                entry_q [mbrs_pkg::QDEPTH];
  logic [mbrs_pkg::QPTR_W-1:0]   wr_ptr_q;
  logic [mbrs_pkg::QPTR_W-1:0]   rd_ptr_q;
  logic [mbrs_pkg::QCNT_W-1:0]   cnt_q;

  assign ready_o = cnt_q != mbrs_pkg::QCNT_W'(mbrs_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == mbrs_pkg::QPTR_W'(mbrs_pkg::QDEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == mbrs_pkg::QPTR_W'(mbrs_pkg::QDEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  `ASSERT_NEVER(a_push_when_full, push_i && !ready_o, "queue written while full")
  `ASSERT_NEVER(a_pop_when_empty, pop_i && !valid_o, "queue read while empty")

endmodule

`default_nettype wire

### src/mbrs_back.sv
`default_nettype none

`include "assert_macros.svh"

module mbrs_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_valid_i,
  input  wire mbrs_pkg::cmd_t                      q_cmd_i,
  output logic                                     q_pop_o,
  output logic                                     init_busy_o,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic [mbrs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o
);

  localparam logic [mbrs_pkg::WIDX_W-1:0] LAST_WORD =
    mbrs_pkg::WIDX_W'(mbrs_pkg::BITMAP_WORDS - 1);

  logic [mbrs_pkg::BMW_W-1:0]   mem [mbrs_pkg::BITMAP_WORDS];
  logic [mbrs_pkg::BMW_W-1:0]   rdata_q;

  mbrs_pkg::back_state_e        state_q, state_d;
  mbrs_pkg::cmd_t               cur_q, cur_d;
  logic [mbrs_pkg::WIDX_W-1:0]  w_q, w_d;
  logic [mbrs_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic                         report_q, report_d;

  logic                         out_valid_q;
  logic                         out_marked_q;
  logic                         out_err_q;
  logic [mbrs_pkg::COUNT_W-1:0] out_count_q;

  logic                         mem_we;
  logic [mbrs_pkg::WIDX_W-1:0]  mem_waddr;
  logic [mbrs_pkg::BMW_W-1:0]   mem_wdata;
  logic                         mem_re;
  logic [mbrs_pkg::WIDX_W-1:0]  mem_raddr;

  logic                         res_set;
  logic                         res_marked;
  logic                         res_err;
  logic [mbrs_pkg::COUNT_W-1:0] res_count;

  logic                         slot_free;
  logic                         same_word;
  logic [mbrs_pkg::BMW_W-1:0]   head_mask;
  logic [mbrs_pkg::COUNT_W:0]   sum;
  logic [mbrs_pkg::COUNT_W-1:0] sat_count;

  assign slot_free  = !out_valid_q || m_axis_tready_i;
  assign same_word  = cur_q.first_w == cur_q.last_w;
  assign head_mask  = mbrs_pkg::range_mask(cur_q.first_b,
                                           same_word ? cur_q.last_b : 6'd63);
  assign sum        = {1'b0, cnt_q} + {16'd0, cur_q.size};
  assign sat_count  = sum[mbrs_pkg::COUNT_W] ? '1 : sum[mbrs_pkg::COUNT_W-1:0];

  assign init_busy_o = (state_q == mbrs_pkg::ST_SWEEP) && !report_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mbrs_pkg::ST_SWEEP;
      w_q      <= '0;
      cnt_q    <= '0;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      w_q      <= w_d;
      cnt_q    <= cnt_d;
      report_q <= report_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    w_d        = w_q;
    cnt_d      = cnt_q;
    report_d   = report_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = w_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = cur_q.first_w;
    res_set    = 1'b0;
    res_marked = 1'b1;
    res_err    = 1'b0;
    res_count  = cnt_q;

    unique case (state_q)
      mbrs_pkg::ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = w_q;
        mem_wdata = '0;
        w_d       = w_q + 1'b1;
        if (w_q == LAST_WORD) begin
          state_d  = mbrs_pkg::ST_IDLE;
          report_d = 1'b0;
          if (report_q) begin
            res_set    = 1'b1;
            res_marked = 1'b0;
            res_count  = '0;
          end
        end
      end

      mbrs_pkg::ST_IDLE: begin
        // An item is taken only when its result has a free output slot.
        if (q_valid_i && slot_free) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          unique case (q_cmd_i.kind)
            mbrs_pkg::CMD_CLEAR: begin
              cnt_d    = '0;
              w_d      = '0;
              report_d = 1'b1;
              state_d  = mbrs_pkg::ST_SWEEP;
            end
            mbrs_pkg::CMD_REJECT: begin
              res_set = 1'b1;
              res_err = q_cmd_i.err;
            end
            mbrs_pkg::CMD_MARK: begin
              mem_re    = 1'b1;
              mem_raddr = q_cmd_i.first_w;
              state_d   = mbrs_pkg::ST_TEST;
            end
            default: begin
              res_set = 1'b1;
            end
          endcase
        end
      end

      mbrs_pkg::ST_TEST: begin
        if ((rdata_q & head_mask) != '0) begin
          res_set = 1'b1;
          state_d = mbrs_pkg::ST_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_q.first_w;
          mem_wdata = rdata_q | head_mask;
          if (same_word) begin
            cnt_d      = sat_count;
            res_set    = 1'b1;
            res_marked = 1'b0;
            res_count  = sat_count;
            state_d    = mbrs_pkg::ST_IDLE;
          end else begin
            w_d     = cur_q.first_w + 1'b1;
            state_d = mbrs_pkg::ST_FILL;
          end
        end
      end

      mbrs_pkg::ST_FILL: begin
        if (w_q != cur_q.last_w) begin
          mem_we    = 1'b1;
          mem_waddr = w_q;
          mem_wdata = '1;
          w_d       = w_q + 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur_q.last_w;
          state_d   = mbrs_pkg::ST_LAST;
        end
      end

      mbrs_pkg::ST_LAST: begin
        mem_we     = 1'b1;
        mem_waddr  = cur_q.last_w;
        mem_wdata  = rdata_q | mbrs_pkg::range_mask(6'd0, cur_q.last_b);
        cnt_d      = sat_count;
        res_set    = 1'b1;
        res_marked = 1'b0;
        res_count  = sat_count;
        state_d    = mbrs_pkg::ST_IDLE;
      end

      default: begin
        state_d = mbrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_set) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_set) begin
      out_marked_q <= res_marked;
      out_err_q    <= res_err;
      out_count_q  <= res_count;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_count_q, out_err_q, out_marked_q};

  `ASSERT_NEVER(a_result_overwrite, res_set && out_valid_q && !m_axis_tready_i,
                "result written over one not yet taken")
  `ASSERT_CLK(a_pop_in_idle, q_pop_o |-> (state_q == mbrs_pkg::ST_IDLE),
              "queue read outside idle")
  `ASSERT_NEVER(a_fill_in_span, (state_q == mbrs_pkg::ST_FILL) && mem_we &&
                ((w_q <= cur_q.first_w) || (w_q >= cur_q.last_w)),
                "inner fill outside the span")

endmodule

`default_nettype wire

### src/mark_bitmap_range_setter.sv
// Channel   Dir  Handshake        Payload
// s_axis    in   tvalid/tready    tuser: opcode; tdata: word_address, size_words
// m_axis    out  tvalid/tready    tdata: marked flag, range_error, marked_count
// cfg       in   cfg_we_i         cfg_idx_i selects heap_start or heap_end
//
// Back end: a mark inside one bitmap word is a RAM read, then a test and write; a
// span also fills each inner word, then reads and writes the last word; a rejected
// word needs no RAM access; a clear zeroes all 1024 words. After reset the back end
// zeroes the bitmap RAM, s_axis_tready low. The classifier register and two-word queue
// sit ahead of the back end, so the front keeps taking words while it works or a result waits.
`default_nettype none

module mark_bitmap_range_setter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // [31:0] word_address, [48:32] size_words, [55:49] zero
  input  wire logic [mbrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [0] opcode
  input  wire logic                                s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [0] marked flag, [1] range_error, [33:2] marked_count, [39:34] zero
  output logic [mbrs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [mbrs_pkg::ADDR_W-1:0]         cfg_wdata_i
);

  logic           init_busy;
  logic           q_ready;
  logic           q_push;
  mbrs_pkg::cmd_t q_cmd_in;
  logic           q_valid;
  mbrs_pkg::cmd_t q_cmd_out;
  logic           q_pop;

  mbrs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .init_busy_i     (init_busy),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd_in)
  );

  mbrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out),
    .pop_i   (q_pop)
  );

  mbrs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd_out),
    .q_pop_o         (q_pop),
    .init_busy_o     (init_busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [mbrs_pkg::ADDR_W-1:0]  addr_t;
  typedef logic [mbrs_pkg::SIZE_W-1:0]  size_t;
  typedef logic [mbrs_pkg::COUNT_W-1:0] count_t;
  typedef logic [mbrs_pkg::BMW_W-1:0]   bmw_t;

  typedef struct packed {
    mbrs_pkg::op_e op;
    addr_t         addr;
    size_t         size;
  } mark_word_t;

  typedef struct packed {
    logic   was_marked;
    logic   range_error;
    count_t marked_count;
  } mark_result_t;

  logic                                 clk_i           = 1'b0;
  logic                                 rst_ni          = 1'b0;
  logic                                 s_axis_tvalid_i = 1'b0;
  logic [mbrs_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i  = '0;
  logic                                 s_axis_tuser_i  = 1'b0;
  logic                                 m_axis_tready_i = 1'b0;
  logic                                 cfg_we_i        = 1'b0;
  logic                                 cfg_idx_i       = 1'b0;
  addr_t                                cfg_wdata_i     = '0;
  wire                                  s_axis_tready_o;
  wire                                  m_axis_tvalid_o;
  wire [mbrs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o;

  mark_bitmap_range_setter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Shadow copy of the block state.
  bmw_t   mark_map [mbrs_pkg::BITMAP_WORDS];
  count_t mark_total = '0;
  addr_t  heap_lo    = mbrs_pkg::HEAP_START_RESET;
  addr_t  heap_hi    = mbrs_pkg::HEAP_END_RESET;

  mark_word_t   pending_words[$];
  mark_result_t due_results[$];
  mark_word_t   cur_word;
  int           src_gap      = 0;
  int           sink_gap     = 0;
  int           fail_cnt     = 0;
  int           hold_left    = 0;
  logic         hold_req     = 1'b0;
  logic         src_idle_on  = 1'b1;
  logic         sink_idle_on = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bmw_t span_bits(input logic [5:0] lo, input logic [5:0] hi);
    logic [mbrs_pkg::BMW_W:0] ones;
    ones = (65'd1 << (hi - lo + 7'd1)) - 65'd1;
    return ones[mbrs_pkg::BMW_W-1:0] << lo;
  endfunction

  // Updates the shadow bitmap and count for one word and returns its result.
  function automatic mark_result_t mark_and_count(input mark_word_t w);
    mark_result_t r;
    logic [63:0]  ix, span_end, a_end, fw, lw, sum;
    bmw_t         msk;
    int k;
    r.was_marked  = 1'b1;
    r.range_error = 1'b0;
    if (w.op == mbrs_pkg::OP_CLEAR) begin
      for (k = 0; k < mbrs_pkg::BITMAP_WORDS; k++) mark_map[k] = '0;
      mark_total = '0;
      r.was_marked = 1'b0;
    end else if (w.addr >= heap_lo && w.addr <= heap_hi && w.size != 0) begin
      ix       = w.addr - heap_lo;
      a_end    = w.addr + w.size;
      span_end = ix + w.size - 1;
      if (a_end > heap_hi || ix + w.size > mbrs_pkg::HEAP_WORDS) begin
        r.range_error = 1'b1;
      end else begin
        fw  = ix >> 6;
        lw  = span_end >> 6;
        msk = span_bits(ix[5:0], (fw == lw) ? span_end[5:0] : 6'd63);
        // Only the first bitmap word decides whether the range counts as marked.
        if ((mark_map[fw] & msk) == '0) begin
          mark_map[fw] = mark_map[fw] | msk;
          for (k = int'(fw) + 1; k < int'(lw); k++) mark_map[k] = '1;
          if (lw != fw) mark_map[lw] = mark_map[lw] | span_bits(6'd0, span_end[5:0]);
          sum = mark_total + w.size;
          mark_total = (sum > 64'hFFFF_FFFF) ? '1 : sum[mbrs_pkg::COUNT_W-1:0];
          r.was_marked = 1'b0;
        end
      end
    end
    r.marked_count = mark_total;
    return r;
  endfunction

  function automatic mark_word_t draw_word();
    mark_word_t w;
    longint unsigned lim, pos;
    int unsigned pick, band;
    pick = $urandom_range(0, 99);
    lim = (heap_hi > heap_lo) ? heap_hi - heap_lo : 1;
    if (lim > mbrs_pkg::HEAP_WORDS) lim = mbrs_pkg::HEAP_WORDS;
    w.op   = mbrs_pkg::OP_MARK;
    w.addr = $urandom;
    w.size = size_t'($urandom_range(0, mbrs_pkg::HEAP_WORDS));
    if (pick < 3) begin
      w.op = mbrs_pkg::OP_CLEAR;
    end else if (pick >= 26) begin
      // Well-formed mark, half of them packed into the bottom of the heap.
      pos = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom;
      w.addr = addr_t'(heap_lo + pos % lim);
      band = $urandom_range(0, 99);
      if (band < 70) w.size = size_t'($urandom_range(1, 8));
      else if (band < 90) w.size = size_t'($urandom_range(1, 130));
      else if (band < 98) w.size = size_t'($urandom_range(1, 1024));
      else w.size = size_t'($urandom_range(1, mbrs_pkg::HEAP_WORDS));
    end else if (pick >= 16) begin
      w.addr = addr_t'(heap_lo + lim + 2 - $urandom_range(0, 80));
      w.size = size_t'($urandom_range(0, 80));
    end else if (pick >= 13) begin
      w.addr = heap_lo - $urandom_range(1, 3);
      w.size = size_t'($urandom_range(1, 16));
    end
    return w;
  endfunction

  task automatic push_mark(input addr_t a, input size_t s);
    pending_words.push_back('{op: mbrs_pkg::OP_MARK, addr: a, size: s});
  endtask

  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++) pending_words.push_back(draw_word());
  endtask

  task automatic write_reg(input mbrs_pkg::cfg_reg_e idx, input addr_t val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mbrs_pkg::CFG_HEAP_START) heap_lo = val;
    else heap_hi = val;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || s_axis_tvalid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Word driver: a word leaves the queue only after its idle gap has run out.
  always @(posedge clk_i) begin : word_drv
    int gap;
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      gap = src_gap;
      if (s_axis_tvalid_i) begin
        due_results.push_back(mark_and_count(cur_word));
        gap = src_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (gap > 0) begin
        src_gap = gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        s_axis_tdata_i  <= {{(mbrs_pkg::IN_TDATA_W - mbrs_pkg::ADDR_W - mbrs_pkg::SIZE_W){1'b0}},
                            cur_word.size, cur_word.addr};
        s_axis_tuser_i  <= cur_word.op;
        s_axis_tvalid_i <= 1'b1;
        src_gap = 0;
      end else begin
        s_axis_tvalid_i <= 1'b0;
        src_gap = 0;
      end
    end
  end

  // Long receiver hold-off, armed by the stimulus.
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) hold_left <= 400;
  end

  always @(posedge clk_i) begin : result_mon
    mark_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.was_marked   = m_axis_tdata_o[0];
        got.range_error  = m_axis_tdata_o[1];
        got.marked_count = m_axis_tdata_o[33:2];
        if (due_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected word: marked=%0b err=%0b count=%0d",
                     got.was_marked, got.range_error, got.marked_count);
        end else begin
          want = due_results.pop_front();
          if (got.was_marked !== want.was_marked ||
              got.range_error !== want.range_error ||
              got.marked_count !== want.marked_count) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: expected marked=%0b err=%0b count=%0d, got %0b %0b %0d",
                       want.was_marked, want.range_error, want.marked_count,
                       got.was_marked, got.range_error, got.marked_count);
          end
        end
        sink_gap = sink_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (hold_left != 0) begin
        m_axis_tready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin : stim
    int k;
    for (k = 0; k < mbrs_pkg::BITMAP_WORDS; k++) mark_map[k] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default heap, directed corners first.
    write_reg(mbrs_pkg::CFG_HEAP_START, 32'd0);
    write_reg(mbrs_pkg::CFG_HEAP_END, 32'd65536);
    push_mark(32'd0, 17'd1);
    push_mark(32'd0, 17'd1);
    push_mark(32'd5, 17'd0);
    push_mark(32'd65536, 17'd1);
    push_mark(32'd65535, 17'd2);
    push_mark(32'd65535, 17'd1);
    push_mark(32'd60, 17'd10);
    push_mark(32'd64, 17'd64);
    // A bit set further on does not stop a range whose first word is clear.
    push_mark(32'd1000, 17'd1);
    push_mark(32'd900, 17'd200);
    push_mark(32'hFFFF_FFFF, 17'd65536);
    pending_words.push_back('{op: mbrs_pkg::OP_CLEAR, addr: '1, size: '1});
    push_mark(32'd0, 17'd65536);
    push_mark(32'd12345, 17'd7);
    pending_words.push_back('{op: mbrs_pkg::OP_CLEAR, addr: '0, size: '0});
    push_mark(32'd63, 17'd1);
    push_mark(32'd64, 17'd64);
    push_mark(32'd127, 17'd2);
    queue_random(200);
    wait_idle();
    queue_random(150);
    wait_idle();

    // Small heap away from zero, with the receiver held off for a while.
    write_reg(mbrs_pkg::CFG_HEAP_START, 32'h1000_0000);
    write_reg(mbrs_pkg::CFG_HEAP_END, 32'h1000_1388);
    queue_random(300);
    hold_req <= 1'b1;
    while (hold_left == 0) @(posedge clk_i);
    hold_req <= 1'b0;
    wait_idle();

    // Heap wider than the bitmap, no idle cycles on either side.
    src_idle_on  <= 1'b0;
    sink_idle_on <= 1'b0;
    write_reg(mbrs_pkg::CFG_HEAP_START, 32'd0);
    write_reg(mbrs_pkg::CFG_HEAP_END, 32'hFFFF_FFFF);
    push_mark(32'd65000, 17'd1000);
    push_mark(32'h8000_0000, 17'd1);
    queue_random(300);
    wait_idle();

    // Heap at the top of the address space.
    src_idle_on <= 1'b1;
    write_reg(mbrs_pkg::CFG_HEAP_START, 32'hFFFF_0000);
    write_reg(mbrs_pkg::CFG_HEAP_END, 32'hFFFF_FFFF);
    push_mark(32'hFFFF_FFFF, 17'd1);
    push_mark(32'hFFFF_FFFE, 17'd1);
    push_mark(32'hFFFE_FFFF, 17'd1);
    queue_random(250);
    wait_idle();

    // Start above end: every address lies outside the heap.
    sink_idle_on <= 1'b1;
    write_reg(mbrs_pkg::CFG_HEAP_START, 32'hFFFF_FFFF);
    write_reg(mbrs_pkg::CFG_HEAP_END, 32'd0);
    push_mark(32'd0, 17'd1);
    push_mark(32'hFFFF_FFFF, 17'd1);
    queue_random(50);
    wait_idle();

    src_idle_on <= 1'b0;
    write_reg(mbrs_pkg::CFG_HEAP_START, 32'h0001_2345);
    write_reg(mbrs_pkg::CFG_HEAP_END, 32'h0002_2345);
    queue_random(200);
    wait_idle();

    repeat (1100) @(posedge clk_i);
    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("mark_bitmap_range_setter regression: pass");
    end else begin
      $display("mark_bitmap_range_setter regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("mark_bitmap_range_setter regression: fail");
    $finish;
  end

endmodule
